>>> rtl/lfpc_pkg.sv
// ----------------------------------------------------------------------------
// lfpc_pkg
// Types and constants shared by the line follower PWM and line counter core.
// ----------------------------------------------------------------------------
package lfpc_pkg;

  localparam int unsigned SpeedW   = 5;
  localparam int unsigned TickW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SPEED_STRAIGHT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_TURN_INNER = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SPEED_TURN_OUTER = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PWM_PERIOD       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TICKS   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN_TICKS   = 3'd5;

  // configuration reset values
  localparam logic [SpeedW-1:0] SPEED_STRAIGHT_RST   = 5'd9;
  localparam logic [SpeedW-1:0] SPEED_TURN_INNER_RST = 5'd5;
  localparam logic [SpeedW-1:0] SPEED_TURN_OUTER_RST = 5'd5;
  localparam logic [SpeedW-1:0] PWM_PERIOD_RST       = 5'd20;
  localparam logic [TickW-1:0]  DEBOUNCE_TICKS_RST   = 8'd20;
  localparam logic [TickW-1:0]  COOLDOWN_TICKS_RST   = 8'd100;

  typedef enum logic [1:0] {
    PH_WAIT_BLACK = 2'd0,
    PH_ON_BLACK   = 2'd1,
    PH_WAIT_WHITE = 2'd2,
    PH_COOLING    = 2'd3
  } line_phase_t;

  typedef struct packed {
    logic left_sensor;
    logic right_sensor;
  } in_item_t;

  typedef struct packed {
    logic             left_pwm;
    logic             right_pwm;
    logic             left_reverse;
    logic             right_reverse;
    logic [TickW-1:0] lines_seen;
    logic             line_pulse;
  } out_item_t;

  // line counter status toward the top level
  typedef struct packed {
    logic [TickW-1:0] lines_seen;
    logic             line_pulse;
    line_phase_t      phase;
  } line_stat_t;

endpackage

>>> rtl/lfpc_line_counter.sv
// ----------------------------------------------------------------------------
// lfpc_line_counter
// Four-phase line counter: wait black, on black, debounce white, cool down.
// ----------------------------------------------------------------------------
module lfpc_line_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  logic                            left_white,
  input  logic                            right_white,
  input  logic [lfpc_pkg::TickW-1:0]      debounce_ticks,
  input  logic [lfpc_pkg::TickW-1:0]      cooldown_ticks,
  output lfpc_pkg::line_stat_t            stat
);

  lfpc_pkg::line_phase_t      phase_r, phase_nxt;
  logic [lfpc_pkg::TickW-1:0] white_run_r, white_run_nxt;
  logic [lfpc_pkg::TickW-1:0] cool_r, cool_nxt;
  logic [lfpc_pkg::TickW-1:0] total_r, total_nxt;
  logic [lfpc_pkg::TickW-1:0] run_inc;
  logic                       pulse;

  assign run_inc = white_run_r + 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    white_run_nxt = white_run_r;
    cool_nxt      = cool_r;
    total_nxt     = total_r;
    pulse         = 1'b0;
    case (phase_r)
      lfpc_pkg::PH_WAIT_BLACK: begin
        if (!left_white && !right_white) begin
          phase_nxt = lfpc_pkg::PH_ON_BLACK;
        end
      end
      lfpc_pkg::PH_ON_BLACK: begin
        if (left_white || right_white) begin
          phase_nxt     = lfpc_pkg::PH_WAIT_WHITE;
          white_run_nxt = '0;
        end
      end
      lfpc_pkg::PH_WAIT_WHITE: begin
        if (left_white && right_white) begin
          white_run_nxt = run_inc;
          if (run_inc >= debounce_ticks) begin
            total_nxt     = total_r + 1'b1;
            phase_nxt     = lfpc_pkg::PH_COOLING;
            cool_nxt      = cooldown_ticks;
            white_run_nxt = '0;
            pulse         = 1'b1;
          end
        end else begin
          white_run_nxt = '0;
        end
      end
      default: begin
        if (cool_r != '0) begin
          cool_nxt = cool_r - 1'b1;
        end else begin
          phase_nxt = lfpc_pkg::PH_WAIT_BLACK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lfpc_pkg::PH_WAIT_BLACK;
      white_run_r <= '0;
      cool_r      <= '0;
      total_r     <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      white_run_r <= white_run_nxt;
      cool_r      <= cool_nxt;
      total_r     <= total_nxt;
    end
  end

  assign stat.lines_seen = total_nxt;
  assign stat.line_pulse = pulse;
  assign stat.phase      = phase_r;

endmodule

>>> rtl/line_follower_pwm_and_line_counter_core.sv
// ----------------------------------------------------------------------------
// line_follower_pwm_and_line_counter_core
// Per-tick wheel PWM, tank steering from two track sensors, and line counting.
// ----------------------------------------------------------------------------
//  channel  | ports                       | handshake
//  ---------+-----------------------------+---------------------------
//  input    | in_valid, in_ready, in_data | accept on valid & ready
//  result   | out_valid, out_ready, out_data | accept on valid & ready
//  config   | cfg_we, cfg_index, cfg_wdata| write on cfg_we, no wait
//
// One item per cycle: an input register feeds the step logic, which writes the
// result register; out_valid rises when the item reaches the result register.
// Both stages advance whenever the result register is empty or being taken.
// Reset (synchronous, active low) loads register defaults, clears all but data registers.
// Unknown config indexes are ignored.
// ----------------------------------------------------------------------------
module line_follower_pwm_and_line_counter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lfpc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lfpc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [lfpc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [lfpc_pkg::CfgDataW-1:0]     cfg_wdata
);

  // configuration
  logic [lfpc_pkg::SpeedW-1:0] speed_straight_r, speed_turn_inner_r, speed_turn_outer_r;
  logic [lfpc_pkg::SpeedW-1:0] pwm_period_r;
  logic [lfpc_pkg::TickW-1:0]  debounce_ticks_r, cooldown_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_straight_r   <= lfpc_pkg::SPEED_STRAIGHT_RST;
      speed_turn_inner_r <= lfpc_pkg::SPEED_TURN_INNER_RST;
      speed_turn_outer_r <= lfpc_pkg::SPEED_TURN_OUTER_RST;
      pwm_period_r       <= lfpc_pkg::PWM_PERIOD_RST;
      debounce_ticks_r   <= lfpc_pkg::DEBOUNCE_TICKS_RST;
      cooldown_ticks_r   <= lfpc_pkg::COOLDOWN_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lfpc_pkg::REG_SPEED_STRAIGHT:   speed_straight_r   <= cfg_wdata[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_SPEED_TURN_INNER: speed_turn_inner_r <= cfg_wdata[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_SPEED_TURN_OUTER: speed_turn_outer_r <= cfg_wdata[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_PWM_PERIOD:       pwm_period_r       <= cfg_wdata[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_r   <= cfg_wdata;
        lfpc_pkg::REG_COOLDOWN_TICKS:   cooldown_ticks_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic               s1_valid_r;
  lfpc_pkg::in_item_t s1_data_r;
  logic               out_valid_r;
  lfpc_pkg::out_item_t out_data_r, res;
  logic               out_load;
  logic               s1_free;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_free  = !s1_valid_r || out_load;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  // PWM and steering
  logic [lfpc_pkg::SpeedW-1:0] pwm_cnt_r, pwm_cnt_nxt, pwm_inc;
  logic [lfpc_pkg::SpeedW-1:0] left_speed_r, left_speed_nxt;
  logic [lfpc_pkg::SpeedW-1:0] right_speed_r, right_speed_nxt;
  logic                        lw, rw, lrev, rrev;
  lfpc_pkg::line_stat_t        line_stat;

  assign lw      = s1_data_r.left_sensor;
  assign rw      = s1_data_r.right_sensor;
  assign pwm_inc = pwm_cnt_r + 1'b1;
  assign pwm_cnt_nxt = (pwm_inc >= pwm_period_r) ? '0 : pwm_inc;

  always_comb begin
    if (!lw && rw) begin
      left_speed_nxt  = speed_turn_outer_r;
      right_speed_nxt = speed_turn_inner_r;
      lrev            = 1'b0;
      rrev            = 1'b1;
    end else if (lw && !rw) begin
      left_speed_nxt  = speed_turn_inner_r;
      right_speed_nxt = speed_turn_outer_r;
      lrev            = 1'b1;
      rrev            = 1'b0;
    end else begin
      left_speed_nxt  = speed_straight_r;
      right_speed_nxt = speed_straight_r;
      lrev            = 1'b0;
      rrev            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_cnt_r     <= '0;
      left_speed_r  <= '0;
      right_speed_r <= '0;
    end else if (out_load) begin
      pwm_cnt_r     <= pwm_cnt_nxt;
      left_speed_r  <= left_speed_nxt;
      right_speed_r <= right_speed_nxt;
    end
  end

  lfpc_line_counter u_line_counter (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (out_load),
    .left_white     (lw),
    .right_white    (rw),
    .debounce_ticks (debounce_ticks_r),
    .cooldown_ticks (cooldown_ticks_r),
    .stat           (line_stat)
  );

  always_comb begin
    res.left_pwm      = (pwm_inc <= left_speed_r);
    res.right_pwm     = (pwm_inc <= right_speed_r);
    res.left_reverse  = lrev;
    res.right_reverse = rrev;
    res.lines_seen    = line_stat.lines_seen;
    res.line_pulse    = line_stat.line_pulse;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a held input item stays in the input register until it moves on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register dropped a stalled item");

  // a counted line always leaves the counter cooling down
  a_pulse_cool: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res.line_pulse |=> line_stat.phase == lfpc_pkg::PH_COOLING)
    else $error("line counted without entering cooldown");

  // a stalled result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

>>> tb/line_follower_pwm_and_line_counter_core_test.sv
// ----------------------------------------------------------------------------
// line_follower_pwm_and_line_counter_core_test
// Feeds sensor ticks through the core under random handshake stalls and checks
// each drive item against a software twin of the PWM, steering and line
// counter. The run covers several register settings, extremes included.
// ----------------------------------------------------------------------------
module line_follower_pwm_and_line_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned LongHold  = 80;

  // decoded by nothing, writes here must leave the setting alone
  localparam logic [lfpc_pkg::CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [lfpc_pkg::CfgIdxW-1:0] REG_SPARE_7 = 3'd7;

  // 0 is black; as a 2-bit value: 0 both black, 1 left dark, 2 right dark, 3 white
  localparam lfpc_pkg::in_item_t ON_LINE    = '{left_sensor: 1'b0, right_sensor: 1'b0};
  localparam lfpc_pkg::in_item_t LEFT_DARK  = '{left_sensor: 1'b0, right_sensor: 1'b1};
  localparam lfpc_pkg::in_item_t RIGHT_DARK = '{left_sensor: 1'b1, right_sensor: 1'b0};
  localparam lfpc_pkg::in_item_t ALL_WHITE  = '{left_sensor: 1'b1, right_sensor: 1'b1};

  class line_follower_twin;
    logic [lfpc_pkg::SpeedW-1:0] straight_spd, inner_spd, outer_spd, period;
    logic [lfpc_pkg::TickW-1:0]  debounce, cooldown;
    logic [lfpc_pkg::SpeedW-1:0] pwm_cnt, left_spd, right_spd;
    lfpc_pkg::line_phase_t       phase;
    logic [lfpc_pkg::TickW-1:0]  white_run, cool_left, line_count;
    lfpc_pkg::out_item_t         pending_drive[$];
    int unsigned                 mismatches;

    function new();
      straight_spd = lfpc_pkg::SPEED_STRAIGHT_RST;
      inner_spd    = lfpc_pkg::SPEED_TURN_INNER_RST;
      outer_spd    = lfpc_pkg::SPEED_TURN_OUTER_RST;
      period       = lfpc_pkg::PWM_PERIOD_RST;
      debounce     = lfpc_pkg::DEBOUNCE_TICKS_RST;
      cooldown     = lfpc_pkg::COOLDOWN_TICKS_RST;
      pwm_cnt      = '0;
      left_spd     = '0;
      right_spd    = '0;
      phase        = lfpc_pkg::PH_WAIT_BLACK;
      white_run    = '0;
      cool_left    = '0;
      line_count   = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [lfpc_pkg::CfgIdxW-1:0] idx,
                          logic [lfpc_pkg::CfgDataW-1:0] val);
      case (idx)
        lfpc_pkg::REG_SPEED_STRAIGHT:   straight_spd = val[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_SPEED_TURN_INNER: inner_spd    = val[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_SPEED_TURN_OUTER: outer_spd    = val[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_PWM_PERIOD:       period       = val[lfpc_pkg::SpeedW-1:0];
        lfpc_pkg::REG_DEBOUNCE_TICKS:   debounce     = val;
        lfpc_pkg::REG_COOLDOWN_TICKS:   cooldown     = val;
        default: ;
      endcase
    endfunction

    function void take_tick(lfpc_pkg::in_item_t t);
      lfpc_pkg::out_item_t d;
      d = '0;
      // levels use the speeds picked on the previous tick
      pwm_cnt = pwm_cnt + 1'b1;
      d.left_pwm  = (pwm_cnt <= left_spd);
      d.right_pwm = (pwm_cnt <= right_spd);
      if (pwm_cnt >= period) pwm_cnt = '0;

      if (!t.left_sensor && t.right_sensor) begin
        left_spd        = outer_spd;
        right_spd       = inner_spd;
        d.right_reverse = 1'b1;
      end else if (t.left_sensor && !t.right_sensor) begin
        left_spd       = inner_spd;
        right_spd      = outer_spd;
        d.left_reverse = 1'b1;
      end else begin
        left_spd  = straight_spd;
        right_spd = straight_spd;
      end

      case (phase)
        lfpc_pkg::PH_WAIT_BLACK: begin
          if (!t.left_sensor && !t.right_sensor) phase = lfpc_pkg::PH_ON_BLACK;
        end
        lfpc_pkg::PH_ON_BLACK: begin
          if (t.left_sensor || t.right_sensor) begin
            phase     = lfpc_pkg::PH_WAIT_WHITE;
            white_run = '0;
          end
        end
        lfpc_pkg::PH_WAIT_WHITE: begin
          if (t.left_sensor && t.right_sensor) begin
            white_run = white_run + 1'b1;
            if (white_run >= debounce) begin
              line_count   = line_count + 1'b1;
              phase        = lfpc_pkg::PH_COOLING;
              cool_left    = cooldown;
              white_run    = '0;
              d.line_pulse = 1'b1;
            end
          end else begin
            white_run = '0;
          end
        end
        default: begin
          if (cool_left != 0) cool_left = cool_left - 1'b1;
          else phase = lfpc_pkg::PH_WAIT_BLACK;
        end
      endcase
      d.lines_seen = line_count;
      pending_drive.push_back(d);
    endfunction

    function void field_ok(string name, logic [lfpc_pkg::TickW-1:0] want,
                           logic [lfpc_pkg::TickW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void bit_ok(string name, logic want, logic got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_drive(lfpc_pkg::out_item_t got);
      lfpc_pkg::out_item_t want;
      if (pending_drive.size() == 0) begin
        $error("drive item with no tick pending: %p", got);
        mismatches++;
      end else begin
        want = pending_drive.pop_front();
        bit_ok("left_pwm", want.left_pwm, got.left_pwm);
        bit_ok("right_pwm", want.right_pwm, got.right_pwm);
        bit_ok("left_reverse", want.left_reverse, got.left_reverse);
        bit_ok("right_reverse", want.right_reverse, got.right_reverse);
        field_ok("lines_seen", want.lines_seen, got.lines_seen);
        bit_ok("line_pulse", want.line_pulse, got.line_pulse);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  lfpc_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  lfpc_pkg::out_item_t           out_data;
  logic                          cfg_we    = 1'b0;
  logic [lfpc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [lfpc_pkg::CfgDataW-1:0] cfg_wdata = '0;

  bit                steady;
  bit                hold_results;
  int unsigned       fed;
  line_follower_twin twin = new();

  line_follower_pwm_and_line_counter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) twin.take_tick(in_data);
      if (out_valid && out_ready) twin.match_drive(out_data);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("line_follower_pwm_and_line_counter_core test failed");
    $finish;
  end

  initial begin : result_sink
    int unsigned r, n;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        n = (r < 55) ? $urandom_range(1, 6) :
            (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 25);
        out_ready <= (r < 55);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic lfpc_pkg::in_item_t any_tick(input int unsigned lo,
                                                  input int unsigned hi);
    logic [1:0] v;
    v = 2'($urandom_range(hi, lo));
    return v;
  endfunction

  task automatic feed(input lfpc_pkg::in_item_t t);
    int unsigned r, gap;
    r   = $urandom_range(0, 99);
    gap = (steady || r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fed++;
  endtask

  // stop offering, let every drive item come out, then cover the pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (twin.pending_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lfpc_pkg::CfgIdxW-1:0] idx,
                           input logic [lfpc_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    twin.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // speed and period writes carry junk in the bits above the register width
  task automatic load_setting(input int unsigned straight, inner, outer, period, deb, cool);
    write_reg(lfpc_pkg::REG_SPEED_STRAIGHT, {3'($urandom), 5'(straight)});
    write_reg(lfpc_pkg::REG_SPEED_TURN_INNER, {3'($urandom), 5'(inner)});
    write_reg(lfpc_pkg::REG_SPEED_TURN_OUTER, {3'($urandom), 5'(outer)});
    write_reg(lfpc_pkg::REG_PWM_PERIOD, {3'($urandom), 5'(period)});
    write_reg(lfpc_pkg::REG_DEBOUNCE_TICKS, 8'(deb));
    write_reg(lfpc_pkg::REG_COOLDOWN_TICKS, 8'(cool));
  endtask

  // one line crossing: black, leave it, a white run long enough to count, cooldown.
  // tight gives the shortest crossing the counter accepts.
  task automatic cross_line(input int unsigned deb, input int unsigned cool, input bit tight);
    repeat (tight ? 1 : $urandom_range(1, 3)) feed(ON_LINE);
    feed(any_tick(1, 3));
    if (!tight) begin
      repeat ($urandom_range(0, 2)) feed(any_tick(0, 2));
      // a white run broken off short of the debounce count
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(0, deb > 0 ? deb - 1 : 0)) feed(ALL_WHITE);
        feed(any_tick(0, 2));
      end
    end
    repeat (deb == 0 ? 1 : deb) feed(ALL_WHITE);
    repeat (tight ? 1 : cool + 1 + $urandom_range(0, 2)) feed(any_tick(0, 3));
  endtask

  task automatic roam(input int unsigned n, input int unsigned deb, input int unsigned cool);
    int unsigned stop;
    stop = fed + n;
    while (fed < stop) begin
      if ($urandom_range(0, 4) != 0) cross_line(deb, cool, 1'b0);
      else repeat ($urandom_range(1, 4)) feed(any_tick(0, 3));
    end
  endtask

  initial begin : stimulus
    lfpc_pkg::in_item_t seq[$];
    int unsigned        deb, cool;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults, wheel speeds still zero on the first tick
    seq = {ON_LINE, LEFT_DARK, RIGHT_DARK, ALL_WHITE, ON_LINE, ALL_WHITE, ALL_WHITE, LEFT_DARK};
    foreach (seq[i]) feed(seq[i]);
    wait_drained();

    // period zero, debounce zero, cooldown zero; spare indexes must do nothing
    write_reg(lfpc_pkg::REG_SPEED_STRAIGHT, 8'hFF);
    write_reg(lfpc_pkg::REG_SPEED_TURN_INNER, 8'hE0);
    write_reg(lfpc_pkg::REG_SPEED_TURN_OUTER, 8'h3F);
    write_reg(lfpc_pkg::REG_PWM_PERIOD, 8'h00);
    write_reg(lfpc_pkg::REG_DEBOUNCE_TICKS, 8'h00);
    write_reg(lfpc_pkg::REG_COOLDOWN_TICKS, 8'h00);
    write_reg(REG_SPARE_6, 8'hFF);
    write_reg(REG_SPARE_7, 8'h55);
    seq = {ON_LINE, RIGHT_DARK, ALL_WHITE, ALL_WHITE, ON_LINE, LEFT_DARK, ALL_WHITE, ON_LINE};
    foreach (seq[i]) feed(seq[i]);
    wait_drained();

    // broken white run restarts the debounce; cooldown of two ticks
    load_setting(0, 31, 0, 31, 3, 2);
    seq = {ON_LINE, ALL_WHITE, ALL_WHITE, ALL_WHITE, RIGHT_DARK, ALL_WHITE, ALL_WHITE,
           ALL_WHITE, LEFT_DARK, ON_LINE, ALL_WHITE};
    foreach (seq[i]) feed(seq[i]);
    wait_drained();

    // receiver holds off while ticks keep coming
    load_setting($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31), 31, 4, 3);
    hold_results = 1'b1;
    roam(80, 4, 3);
    wait_drained();

    // speed and period extremes, cooldown longer than the phase
    load_setting(31, 31, 0, 1, 1, 255);
    roam(50, 1, 2);
    wait_drained();

    deb  = $urandom_range(1, 6);
    cool = $urandom_range(0, 8);
    load_setting($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(1, 31), deb, cool);
    roam(40, deb, cool);
    wait_drained();
    roam(40, deb, cool);
    wait_drained();

    // back-to-back lines, first half without any stalls
    load_setting($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(1, 31), 1, 0);
    steady = 1'b1;
    repeat (6) cross_line(1, 0, 1'b1);
    steady = 1'b0;
    repeat (6) cross_line(1, 0, 1'b1);
    wait_drained();

    load_setting($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(1, 31), 255, 0);
    roam(40, 6, 2);
    wait_drained();

    deb  = $urandom_range(0, 8);
    cool = $urandom_range(0, 8);
    load_setting($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 31), deb, cool);
    roam(80, deb, cool);
    wait_drained();

    if (twin.mismatches == 0 && twin.pending_drive.size() == 0) begin
      $display("line_follower_pwm_and_line_counter_core test passed");
    end else begin
      $display("line_follower_pwm_and_line_counter_core test failed");
    end
    $finish;
  end

endmodule
